### rtl/core/isolated_pixel_frame_check_unit_defines.svh
// ----------------------------------------------------------------------------
// isolated pixel frame check - assertion macros
// shared assertion helpers for the checker of the frame check unit
// ----------------------------------------------------------------------------
`ifndef ISOLATED_PIXEL_FRAME_CHECK_UNIT_DEFINES_SVH
`define ISOLATED_PIXEL_FRAME_CHECK_UNIT_DEFINES_SVH

// clocked assertion, ignored while reset is asserted
`define IPFC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds during reset
`define IPFC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/ipfc_pkg.sv
// ----------------------------------------------------------------------------
// ipfc_pkg
// shared types and constants of the isolated pixel frame check unit
// ----------------------------------------------------------------------------
package ipfc_pkg;

  localparam int unsigned MAX_COLS_DEF = 64;
  localparam int unsigned MAX_ROWS_DEF = 64;

  // size register width
  localparam int unsigned CFG_W   = 7;
  // apb address width, registers at byte address 4*i
  localparam int unsigned ADDR_W  = 3;
  localparam int unsigned APB_W   = 32;
  // stream data width, whole bytes
  localparam int unsigned TDATA_W = 8;

  typedef enum logic {
    REG_ROWS = 1'b0,
    REG_COLS = 1'b1
  } ipfc_reg_e;

  // control from the unit top to the line buffer
  typedef struct packed {
    logic clear;
    logic step;
  } ipfc_ctl_t;

  // status from the line buffer for the item now at the check stage
  typedef struct packed {
    logic last;
    logic verdict;
  } ipfc_res_t;

endpackage

### rtl/core/ipfc_line_buf.sv
// ----------------------------------------------------------------------------
// ipfc_line_buf
// row buffers, position counters and the per-pixel neighbour check
// ----------------------------------------------------------------------------
module ipfc_line_buf import ipfc_pkg::*; #(
  parameter int unsigned MaxCols = MAX_COLS_DEF,
  parameter int unsigned MaxRows = MAX_ROWS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ipfc_ctl_t        ctl_i,
  input  logic             pixel_i,
  input  logic [CFG_W-1:0] rows_cfg_i,
  input  logic [CFG_W-1:0] cols_cfg_i,
  output ipfc_res_t        res_o
);

  localparam int unsigned CW = (MaxCols > 1) ? $clog2(MaxCols) : 1;
  localparam int unsigned RW = (MaxRows > 1) ? $clog2(MaxRows) : 1;

  logic [MaxCols-1:0] above_q, middle_q, incoming_q;
  logic [CW-1:0]      col_q;
  logic [RW-1:0]      row_q;
  logic               verdict_q;

  logic [CW-1:0]      col_last;
  logic [RW-1:0]      row_last;
  logic [MaxCols-1:0] mid_l, mid_r, inc_l1, inc_l2, inc_w;
  logic               at_last_col, at_last_row;
  logic               lonely_mid, lonely_prev, lonely_cur;
  logic               verdict_new;

  // size registers: zero means one, above the maximum saturates
  always_comb begin
    if (cols_cfg_i == '0) begin
      col_last = '0;
    end else if (32'(cols_cfg_i) > MaxCols) begin
      col_last = CW'(MaxCols - 1);
    end else begin
      col_last = CW'(cols_cfg_i - 1'b1);
    end
    if (rows_cfg_i == '0) begin
      row_last = '0;
    end else if (32'(rows_cfg_i) > MaxRows) begin
      row_last = RW'(MaxRows - 1);
    end else begin
      row_last = RW'(rows_cfg_i - 1'b1);
    end
  end

  // shifted copies give the left and right neighbour at the same column index
  assign mid_l  = middle_q << 1;
  assign mid_r  = middle_q >> 1;
  assign inc_l1 = incoming_q << 1;
  assign inc_l2 = incoming_q << 2;

  assign at_last_col = (col_q == col_last);
  assign at_last_row = (row_q == row_last);

  always_comb begin
    inc_w        = incoming_q;
    inc_w[col_q] = pixel_i;
  end

  // middle row pixel, incoming pixel is its lower neighbour
  assign lonely_mid = middle_q[col_q] & ~above_q[col_q] & ~pixel_i & ~mid_l[col_q]
                    & ~(mid_r[col_q] & ~at_last_col);
  // last row has nothing below: check its previous pixel now that its right is known
  assign lonely_prev = at_last_row & inc_l1[col_q] & ~mid_l[col_q] & ~inc_l2[col_q]
                     & ~pixel_i;
  // last pixel of the frame has neither right nor lower neighbour
  assign lonely_cur = at_last_row & at_last_col & pixel_i & ~middle_q[col_q]
                    & ~inc_l1[col_q];

  assign verdict_new = verdict_q & ~(lonely_mid | lonely_prev | lonely_cur);

  assign res_o.last    = at_last_col & at_last_row;
  assign res_o.verdict = verdict_new;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      above_q    <= '0;
      middle_q   <= '0;
      incoming_q <= '0;
      col_q      <= '0;
      row_q      <= '0;
      verdict_q  <= 1'b1;
    end else if (ctl_i.clear || (ctl_i.step && at_last_col && at_last_row)) begin
      above_q    <= '0;
      middle_q   <= '0;
      incoming_q <= '0;
      col_q      <= '0;
      row_q      <= '0;
      verdict_q  <= 1'b1;
    end else if (ctl_i.step) begin
      verdict_q <= verdict_new;
      if (at_last_col) begin
        above_q    <= middle_q;
        middle_q   <= inc_w;
        incoming_q <= '0;
        col_q      <= '0;
        row_q      <= row_q + 1'b1;
      end else begin
        incoming_q <= inc_w;
        col_q      <= col_q + 1'b1;
      end
    end
  end

endmodule

### rtl/core/ipfc_out_queue.sv
// ----------------------------------------------------------------------------
// ipfc_out_queue
// two-entry result queue in front of the master stream port
// ----------------------------------------------------------------------------
module ipfc_out_queue import ipfc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  logic verdict_i,
  output logic full_o,
  output logic valid_o,
  output logic verdict_o,
  input  logic ready_i
);

  logic v0_q, v1_q;
  logic d0_q, d1_q;
  logic pop;

  assign pop       = v0_q & ready_i;
  assign valid_o   = v0_q;
  assign verdict_o = d0_q;
  assign full_o    = v1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
    end else begin
      unique case ({pop, push_i})
        2'b10: begin
          v0_q <= v1_q;
          v1_q <= 1'b0;
        end
        2'b01: begin
          if (v0_q) begin
            v1_q <= 1'b1;
          end else begin
            v0_q <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case ({pop, push_i})
      2'b10: begin
        d0_q <= d1_q;
      end
      2'b01: begin
        if (v0_q) begin
          d1_q <= verdict_i;
        end else begin
          d0_q <= verdict_i;
        end
      end
      2'b11: begin
        if (v1_q) begin
          d0_q <= d1_q;
          d1_q <= verdict_i;
        end else begin
          d0_q <= verdict_i;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

### rtl/core/isolated_pixel_frame_check_unit.sv
// path: the frame's last pixel passes the input register, then the check and the
//   queue write, before its verdict shows on the master port
// throughput: one pixel per cycle; the slave port stalls only when a frame ends
//   while both entries of the two-deep result queue are still waiting
// reset: asynchronous, active low; frame state cleared, both size registers one
// ----------------------------------------------------------------------------
// isolated_pixel_frame_check_unit
// checks a raster binary image frame: does every set pixel have a set
// 4-neighbour; one verdict per frame
// ----------------------------------------------------------------------------
module isolated_pixel_frame_check_unit import ipfc_pkg::*; #(
  parameter int unsigned MaxCols = MAX_COLS_DEF,
  parameter int unsigned MaxRows = MAX_ROWS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // apb configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [APB_W-1:0]   pwdata,
  output logic [APB_W-1:0]   prdata,
  output logic               pready,
  // pixel stream in
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [TDATA_W-1:0] s_axis_tdata,  // [0] pixel, [7:1] zero
  // verdict stream out
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [TDATA_W-1:0] m_axis_tdata   // [0] all_have_neighbour, [7:1] zero
);

  // size registers
  logic [CFG_W-1:0] rows_q, cols_q;
  logic             cfg_wr;
  ipfc_reg_e        cfg_sel;

  // input register in front of the check
  logic s1_valid_q;
  logic s1_pixel_q;
  logic s_fire;
  logic step_ok;

  ipfc_ctl_t ctl;
  ipfc_res_t res;
  logic      q_full;
  logic      q_verdict;

  assign pready  = 1'b1;
  assign cfg_sel = ipfc_reg_e'(paddr[2]);
  assign cfg_wr  = psel & penable & pwrite;

  // reads return the raw register value
  always_comb begin
    unique case (cfg_sel)
      REG_ROWS: prdata = APB_W'(rows_q);
      REG_COLS: prdata = APB_W'(cols_q);
      default:  prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= CFG_W'(1);
      cols_q <= CFG_W'(1);
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_ROWS: rows_q <= pwdata[CFG_W-1:0];
        REG_COLS: cols_q <= pwdata[CFG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // a pixel moves through the check unless it closes a frame with the queue full
  assign step_ok       = ~res.last | ~q_full;
  assign s_axis_tready = ~s1_valid_q | step_ok;
  assign s_fire        = s_axis_tvalid & s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_fire) begin
      s1_valid_q <= 1'b1;
    end else if (step_ok) begin
      s1_valid_q <= 1'b0;
    end
  end

  // pixel payload needs no reset
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      s1_pixel_q <= s_axis_tdata[0];
    end
  end

  // any register write restarts the frame
  assign ctl.clear = cfg_wr;
  assign ctl.step  = s1_valid_q & step_ok;

  ipfc_line_buf #(
    .MaxCols(MaxCols),
    .MaxRows(MaxRows)
  ) u_line_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ctl),
    .pixel_i    (s1_pixel_q),
    .rows_cfg_i (rows_q),
    .cols_cfg_i (cols_q),
    .res_o      (res)
  );

  // verdict of a finished frame goes to the result queue
  ipfc_out_queue u_out_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (ctl.step & res.last),
    .verdict_i (res.verdict),
    .full_o    (q_full),
    .valid_o   (m_axis_tvalid),
    .verdict_o (q_verdict),
    .ready_i   (m_axis_tready)
  );

  assign m_axis_tdata = TDATA_W'(q_verdict);

endmodule

### rtl/core/ipfc_checker.sv
// ----------------------------------------------------------------------------
// ipfc_checker
// port-level checks of the frame check unit, bound to its top level
// ----------------------------------------------------------------------------
`include "isolated_pixel_frame_check_unit_defines.svh"

module ipfc_checker import ipfc_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               psel,
  input logic               penable,
  input logic               pwrite,
  input logic [ADDR_W-1:0]  paddr,
  input logic [APB_W-1:0]   pwdata,
  input logic [APB_W-1:0]   prdata,
  input logic               pready,
  input logic               m_axis_tvalid,
  input logic               m_axis_tready,
  input logic [TDATA_W-1:0] m_axis_tdata
);

  // a stalled verdict holds
  `IPFC_ASSERT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled verdict changed")

  // only the verdict bit of the output byte is ever set
  `IPFC_ASSERT(a_out_pad, clk_i, rst_ni, m_axis_tvalid |-> m_axis_tdata[TDATA_W-1:1] == '0, "output padding not zero")

  // a register reads back what was written the cycle before
  `IPFC_ASSERT(a_cfg_readback, clk_i, rst_ni, psel && penable && pwrite ##1 psel && !pwrite && paddr[2] == $past(paddr[2]) |-> prdata == APB_W'($past(pwdata[CFG_W-1:0])), "size register readback mismatch")

  // the configuration port never waits
  `IPFC_ASSERT_ALWAYS(a_pready, clk_i, pready, "pready low")

endmodule

bind isolated_pixel_frame_check_unit ipfc_checker u_ipfc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .psel          (psel),
  .penable       (penable),
  .pwrite        (pwrite),
  .paddr         (paddr),
  .pwdata        (pwdata),
  .prdata        (prdata),
  .pready        (pready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

### tb/isolated_pixel_frame_check_unit_tb.sv
// ----------------------------------------------------------------------------
// isolated pixel frame check unit testbench
// streams binary image frames of many sizes into the unit, predicts the
// verdict of every complete frame and compares it with the verdict stream;
// the sender idles in bursts, the receiver stalls on its own pattern
// ----------------------------------------------------------------------------
module isolated_pixel_frame_check_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ipfc_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 600000;
  // settle after the last expected verdict has been checked, for margin
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned END_CYCLES = 10;
  // long receiver hold-off, far longer than a few small frames take
  localparam int unsigned LONG_HOLD = 400;
  localparam int unsigned RANDOM_ITEMS = 1200;
  localparam int unsigned MIN_VERDICTS = 48;
  localparam int unsigned REPORT_MAX = 10;
  // phases that must always run: long hold-off and the tall frame
  localparam int unsigned MIN_PHASES = 6;

  typedef enum int unsigned {
    RX_FREE,
    RX_RANDOM,
    RX_PERIODIC
  } rx_mode_e;

  // --------------------------------------------------------------------------
  // frame verdict predictor and store of expected verdicts
  // --------------------------------------------------------------------------
  class verdict_scoreboard;
    bit [MAX_COLS_DEF-1:0] line_above;
    bit [MAX_COLS_DEF-1:0] line_middle;
    bit [MAX_COLS_DEF-1:0] line_incoming;
    int unsigned           col_pos;
    int unsigned           row_pos;
    bit                    frame_ok;
    bit [CFG_W-1:0]        rows_reg;
    bit [CFG_W-1:0]        cols_reg;
    bit                    expected_verdicts[$];
    int unsigned           failures;
    int unsigned           verdicts_seen;

    function new();
      rows_reg = 1;
      cols_reg = 1;
      failures = 0;
      verdicts_seen = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      line_above    = '0;
      line_middle   = '0;
      line_incoming = '0;
      col_pos  = 0;
      row_pos  = 0;
      frame_ok = 1'b1;
    endfunction

    // zero counts as one, anything above the buffer size saturates
    function int unsigned eff_size(bit [CFG_W-1:0] v, int unsigned limit);
      if (v == 0) return 1;
      if (v > limit) return limit;
      return v;
    endfunction

    function void write_reg(ipfc_reg_e r, bit [CFG_W-1:0] v);
      if (r == REG_ROWS) rows_reg = v;
      else cols_reg = v;
      clear_frame();
    endfunction

    // middle-row pixel c is set and none of its 4-neighbours is
    function bit lonely(int unsigned c, int unsigned cols, bit below);
      if (c >= cols || c >= MAX_COLS_DEF) return 1'b0;
      if (!line_middle[c]) return 1'b0;
      if (line_above[c] || below) return 1'b0;
      if (c > 0 && line_middle[c-1]) return 1'b0;
      if (c + 1 < cols && line_middle[c+1]) return 1'b0;
      return 1'b1;
    endfunction

    function void note_pixel(bit p);
      int unsigned cols;
      int unsigned rows;
      int unsigned c;
      cols = eff_size(cols_reg, MAX_COLS_DEF);
      rows = eff_size(rows_reg, MAX_ROWS_DEF);
      c = col_pos;
      if (c >= cols) c = cols - 1;
      line_incoming[c] = p;
      if (lonely(c, cols, p)) frame_ok = 1'b0;
      if (c + 1 < cols) begin
        col_pos = c + 1;
        return;
      end
      line_above    = line_middle;
      line_middle   = line_incoming;
      line_incoming = '0;
      col_pos = 0;
      if (row_pos + 1 < rows) begin
        row_pos++;
        return;
      end
      // last row of the frame sees an empty row below
      for (int unsigned k = 0; k < cols; k++) begin
        if (lonely(k, cols, 1'b0)) frame_ok = 1'b0;
      end
      expected_verdicts.push_back(frame_ok);
      clear_frame();
    endfunction

    function void check_verdict(logic [TDATA_W-1:0] data);
      bit exp_v;
      verdicts_seen++;
      if (expected_verdicts.size() == 0) begin
        if (failures < REPORT_MAX)
          $display("unexpected verdict %b, none pending", data[0]);
        failures++;
        return;
      end
      exp_v = expected_verdicts.pop_front();
      if (data[0] !== exp_v) begin
        if (failures < REPORT_MAX)
          $display("verdict mismatch: expected %b actual %b", exp_v, data[0]);
        failures++;
      end
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [ADDR_W-1:0]  paddr;
  logic [APB_W-1:0]   pwdata;
  logic [APB_W-1:0]   prdata;
  logic               pready;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [TDATA_W-1:0] s_axis_tdata;   // [0] pixel, [7:1] zero
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  logic [TDATA_W-1:0] m_axis_tdata;   // [0] all_have_neighbour, [7:1] zero

  verdict_scoreboard sb;

  // sender burst state
  bit          idle_on;
  int unsigned burst_left;
  // receiver hold-off request, served in the receiver process
  bit          hold_pending;
  int unsigned cycle_count;

  isolated_pixel_frame_check_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // 10 ns clock
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // run limit, far above the slowest correct run
  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // verdict monitor, sampled at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_verdict(m_axis_tdata);
  end

  // receiver: own stall pattern, a new mode picked at random whenever the last one runs out,
  // plus one long hold-off on request
  initial begin
    rx_mode_e    rx_mode;
    int unsigned mode_left;
    int unsigned hold_left;
    int unsigned pat_cnt;
    m_axis_tready = 1'b0;
    rx_mode   = RX_FREE;
    mode_left = 0;
    hold_left = 0;
    pat_cnt   = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_pending) begin
        hold_pending = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          rx_mode   = rx_mode_e'($urandom_range(0, 2));
          mode_left = $urandom_range(50, 300);
        end
        mode_left--;
        pat_cnt++;
        case (rx_mode)
          RX_FREE:     m_axis_tready <= 1'b1;
          RX_RANDOM:   m_axis_tready <= ($urandom_range(0, 99) >= 35);
          RX_PERIODIC: m_axis_tready <= ((pat_cnt % 5) < 3);
          default:     m_axis_tready <= 1'b1;
        endcase
      end
    end
  end

  // all driving tasks are entered and left at a falling edge

  // one register write: setup cycle, then access cycle until pready
  task automatic write_size(input ipfc_reg_e r, input bit [CFG_W-1:0] v);
    logic [APB_W-1:0] wd;
    wd = '0;
    // junk in the upper bits half the time, the register keeps 7 bits
    if ($urandom_range(0, 1)) wd = $urandom();
    wd[CFG_W-1:0] = v;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= wd;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    sb.write_reg(r, v);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
  endtask

  // both size registers, in random order
  task automatic set_sizes(input bit [CFG_W-1:0] rows_v, input bit [CFG_W-1:0] cols_v);
    if ($urandom_range(0, 1)) begin
      write_size(REG_ROWS, rows_v);
      write_size(REG_COLS, cols_v);
    end else begin
      write_size(REG_COLS, cols_v);
      write_size(REG_ROWS, rows_v);
    end
  endtask

  // one pixel item; a gap may open before it when a burst is used up
  task automatic send_pixel(input bit p);
    if (idle_on && burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
      burst_left = $urandom_range(1, 40);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(TDATA_W-1){1'b0}}, p};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_pixel(p);
    if (burst_left > 0) burst_left--;
    @(negedge clk_i);
  endtask

  // pixels of one row-major pattern given as a bit string, lsb first
  task automatic send_pattern(input int unsigned n, input bit [63:0] bits);
    for (int unsigned i = 0; i < n; i++) send_pixel(bits[i]);
  endtask

  // n random pixels, set with the given percentage
  task automatic send_random(input int unsigned n, input int unsigned dens);
    for (int unsigned i = 0; i < n; i++) send_pixel($urandom_range(0, 99) < dens);
  endtask

  // sender stops and waits for every pending verdict, then a short settle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (sb.expected_verdicts.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  function automatic int unsigned pick_density();
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return 10;
      2:       return 35;
      3:       return 60;
      4:       return 85;
      default: return 100;
    endcase
  endfunction

  initial begin
    int unsigned random_items;
    int unsigned phase;
    int unsigned frames;
    int unsigned frame_px;
    int unsigned n;
    bit [CFG_W-1:0] rows_v;
    bit [CFG_W-1:0] cols_v;
    bit big_frame;

    sb = new();
    rst_ni        = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    idle_on       = 1'b0;
    burst_left    = 0;
    hold_pending  = 1'b0;
    random_items  = 0;
    phase         = 0;

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: sizes from reset give a single pixel frame
    send_pixel(1'b1);             // lone set pixel
    send_pixel(1'b0);             // empty frame
    drain();
    set_sizes(7'd1, 7'd2);
    send_pattern(2, 64'b11);      // pair on one row
    send_pattern(2, 64'b01);      // lone pixel at the left edge
    drain();
    set_sizes(7'd3, 7'd1);
    send_pattern(3, 64'b101);     // top and bottom edge both lone
    drain();
    set_sizes(7'd0, 7'd0);        // zero sizes act as one
    send_pixel(1'b1);
    drain();
    set_sizes(7'd2, 7'd3);
    send_pattern(6, 64'b101101);  // vertical pairs at both side edges
    drain();

    // random phases of whole frames, some cut short
    while (random_items < RANDOM_ITEMS || sb.verdicts_seen < MIN_VERDICTS ||
           phase < MIN_PHASES) begin
      big_frame = 1'b0;
      case ($urandom_range(0, 9))
        6: begin
          rows_v = CFG_W'($urandom_range(0, 1));
          cols_v = CFG_W'($urandom_range(64, 127));
        end
        7: begin
          rows_v = CFG_W'($urandom_range(64, 127));
          cols_v = CFG_W'($urandom_range(0, 2));
        end
        8: begin
          rows_v = CFG_W'($urandom_range(0, 3));
          cols_v = CFG_W'($urandom_range(0, 3));
        end
        9: begin
          rows_v = CFG_W'($urandom_range(1, 4));
          cols_v = CFG_W'($urandom_range(9, 20));
        end
        default: begin
          rows_v = CFG_W'($urandom_range(1, 6));
          cols_v = CFG_W'($urandom_range(1, 8));
        end
      endcase
      frames  = $urandom_range(1, 5);
      idle_on = ($urandom_range(0, 3) != 0);
      // one phase of tiny frames under a long receiver hold-off
      if (phase == 2) begin
        rows_v  = 7'd2;
        cols_v  = 7'd2;
        frames  = 40;
        idle_on = 1'b0;
      end
      // one tall dense frame, row register above the maximum
      if (phase == 5) begin
        rows_v    = 7'd127;
        cols_v    = 7'd3;
        frames    = 1;
        big_frame = 1'b1;
      end
      set_sizes(rows_v, cols_v);
      burst_left = $urandom_range(1, 40);
      if (phase == 2) hold_pending = 1'b1;
      frame_px = sb.eff_size(rows_v, MAX_ROWS_DEF) * sb.eff_size(cols_v, MAX_COLS_DEF);
      for (int unsigned f = 0; f < frames; f++) begin
        send_random(frame_px, big_frame ? 90 : pick_density());
        random_items += frame_px;
        // sometimes hold the stream until every verdict is back
        if ($urandom_range(0, 7) == 0) drain();
      end
      // broken frame, cleared by the next register write
      if (frame_px > 1 && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, frame_px - 1);
        send_random(n, pick_density());
        random_items += n;
      end
      drain();
      phase++;
    end

    drain();
    repeat (END_CYCLES) @(negedge clk_i);
    if (sb.failures == 0 && sb.expected_verdicts.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
